### rtl/goce_pkg.sv
package goce_pkg;

	localparam int FRAC_BITS   = 15;
	localparam int ONE_Q       = 1 << FRAC_BITS;
	localparam int HALF_Q      = 1 << (FRAC_BITS - 1);
	localparam int EXP_DEPTH   = 256;
	localparam int EXP_AW      = $clog2(EXP_DEPTH);
	localparam int DIV_NW      = 34;
	localparam int DIV_DW      = 18;
	localparam int QUEUE_DEPTH = 2;

	localparam longint unsigned EXP_R_DEN  = 4 * (EXP_DEPTH - 1);
	localparam longint unsigned EXP_R_BIAS = 2 * (EXP_DEPTH - 1);

	localparam logic CFG_ACTIVE_COUNT = 1'b0;
	localparam logic CFG_SAMPLE_COUNT = 1'b1;

	typedef enum logic {
		ITEM_WRITE,
		ITEM_EVAL
	} item_kind_t;

	typedef struct packed {
		item_kind_t         kind;
		logic [3:0]         entry_index;
		logic [15:0]        center;
		logic [15:0]        half_width;
		logic [15:0]        peak_height;
		logic signed [15:0] skew_x;
		logic [15:0]        shape_y;
		logic [11:0]        sample_index;
	} item_t;

	typedef struct packed {
		logic [15:0]        center;
		logic [15:0]        width;
		logic [15:0]        height;
		logic signed [16:0] skew;
		logic [15:0]        shape;
	} bump_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	typedef logic [15:0] exp_tab_t [EXP_DEPTH];

	// Entry k holds exp(-4k/(EXP_DEPTH-1)) in Q1.15, built from a Q31 series
	// for exp(-z/16) that is squared four times.
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t          tab;
		longint unsigned   r;
		longint unsigned   sum;
		longint unsigned   t;
		longint unsigned   q31;
		int                i;
		q31 = 64'h8000_0000;
		for (int k = 0; k < EXP_DEPTH; k++) begin
			r = ((longint'(k) << 31) + EXP_R_BIAS) / EXP_R_DEN;
			t = (q31 * r) >> 31;
			sum = q31 - t;
			t = ((t * r) >> 31) / 2;
			sum = sum + t;
			t = ((t * r) >> 31) / 3;
			sum = sum - t;
			t = ((t * r) >> 31) / 4;
			sum = sum + t;
			t = ((t * r) >> 31) / 5;
			sum = sum - t;
			t = ((t * r) >> 31) / 6;
			sum = sum + t;
			t = ((t * r) >> 31) / 7;
			sum = sum - t;
			t = ((t * r) >> 31) / 8;
			sum = sum + t;
			t = ((t * r) >> 31) / 9;
			sum = sum - t;
			t = ((t * r) >> 31) / 10;
			sum = sum + t;
			t = ((t * r) >> 31) / 11;
			sum = sum - t;
			t = ((t * r) >> 31) / 12;
			sum = sum + t;
			for (i = 0; i < 4; i++) begin
				sum = (sum * sum + (q31 >> 1)) >> 31;
			end
			tab[k] = 16'((sum + (64'd1 << (30 - FRAC_BITS))) >> (31 - FRAC_BITS));
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

### rtl/goce_ram.sv
module goce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/goce_div.sv
module goce_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  goce_pkg::div_req_t          req,
	output logic                        done,
	output logic [goce_pkg::DIV_NW-1:0] quo
);

	import goce_pkg::*;

	localparam int CW = $clog2(DIV_NW);

	logic [DIV_DW-1:0] rem_q;
	logic [DIV_NW-1:0] qn_q;
	logic [CW-1:0]     cnt_q;
	logic              run_q;
	logic              done_q;
	logic [DIV_DW:0]   shifted;
	logic [DIV_DW:0]   diff;
	logic              fits;

	always_comb begin
		shifted = {rem_q, qn_q[DIV_NW-1]};
		fits = shifted >= {1'b0, req.den};
		diff = shifted - {1'b0, req.den};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
		end else if (req.start) begin
			run_q <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			if (cnt_q == CW'(DIV_NW - 1)) begin
				run_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			qn_q <= req.num;
			cnt_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
			qn_q <= {qn_q[DIV_NW-2:0], fits};
			cnt_q <= cnt_q + CW'(1);
		end
	end

	// The divisor is held by the requester for the whole division.
	assign done = done_q;
	assign quo = qn_q;

endmodule

### rtl/goce_front.sv
module goce_front #(
	parameter int MAX_GAUSSIANS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                mode,
	input  logic [3:0]          entry_index,
	input  logic [15:0]         center,
	input  logic [15:0]         half_width,
	input  logic [15:0]         peak_height,
	input  logic signed [15:0]  skew_x,
	input  logic [15:0]         shape_y,
	input  logic [11:0]         sample_index,
	output logic                busy,
	output logic                q_valid,
	output goce_pkg::item_t     q_item,
	input  logic                q_pop
);

	import goce_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	item_t         mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          push;
	item_t         item;

	// Writes to entries beyond the table are dropped here.
	always_comb begin
		item.kind = mode ? ITEM_EVAL : ITEM_WRITE;
		item.entry_index = entry_index;
		item.center = center;
		item.half_width = half_width;
		item.peak_height = peak_height;
		item.skew_x = skew_x;
		item.shape_y = shape_y;
		item.sample_index = sample_index;
		push = start && !busy && (mode || (int'(entry_index) < MAX_GAUSSIANS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (q_pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (q_pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= item;
		end
	end

	assign busy = cnt_q == CW'(QUEUE_DEPTH);
	assign q_valid = cnt_q != '0;
	assign q_item = mem_q[rd_q];

endmodule

### rtl/goce_back.sv
module goce_back #(
	parameter int MAX_GAUSSIANS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  goce_pkg::item_t q_item,
	output logic            q_pop,
	input  logic [4:0]      active_count,
	input  logic [12:0]     sample_count,
	output logic            done,
	output logic [15:0]     opacity
);

	import goce_pkg::*;

	localparam int IW   = (MAX_GAUSSIANS > 1) ? $clog2(MAX_GAUSSIANS) : 1;
	localparam int CNTW = $clog2(MAX_GAUSSIANS + 1);
	localparam int BW   = $bits(bump_t);
	localparam int PW   = 16 + EXP_AW;
	localparam logic [16:0] ONE17 = 17'(ONE_Q);
	localparam logic [16:0] TWO17 = 17'(2 * ONE_Q);

	typedef enum logic [3:0] {
		S_IDLE,
		S_POS,
		S_RD,
		S_CHK,
		S_DIV,
		S_SQ,
		S_GL,
		S_BL,
		S_HV,
		S_OUT
	} state_t;

	state_t             state_q;
	logic               done_q;
	logic [15:0]        opacity_q;
	logic [CNTW-1:0]    e_q;
	logic [CNTW-1:0]    cnt_q;
	logic [15:0]        x_q;
	logic [16:0]        x1_q;
	logic [15:0]        s_q;
	logic [15:0]        g_q;
	logic [16:0]        h1_q;
	logic [18:0]        best_q;

	div_req_t           div_req;
	logic               div_done;
	logic [DIV_NW-1:0]  div_quo;
	logic               ram_we;
	bump_t              wr_bump;
	logic [BW-1:0]      ram_rdata;
	bump_t              bump;

	logic [12:0]        n_eff;
	logic [12:0]        nm1;
	logic [11:0]        i_eff;
	logic [CNTW-1:0]    cnt_eff;
	logic               last;

	logic signed [19:0] xs;
	logic signed [19:0] ps;
	logic signed [19:0] ws;
	logic signed [19:0] w1s;
	logic signed [19:0] bxs;
	logic signed [19:0] ds;
	logic signed [19:0] dens;
	logic               outside;
	logic               skip_div;
	logic [17:0]        mag;
	logic [17:0]        den_u;

	logic [33:0]        sq;
	logic [PW-1:0]      gpos;
	logic [EXP_AW:0]    gk;
	logic [14:0]        gfr;
	logic [15:0]        ta;
	logic [15:0]        tb;
	logic [15:0]        tdiff;
	logic [31:0]        gprod;
	logic [16:0]        gstep;
	logic [15:0]        g_next;
	logic [16:0]        by;
	logic [16:0]        pb;
	logic [33:0]        m1;
	logic [33:0]        m2;
	logic [33:0]        bsum;
	logic [33:0]        hprod;

	assign bump = bump_t'(ram_rdata);

	always_comb begin
		wr_bump.center = q_item.center;
		wr_bump.width = q_item.half_width;
		wr_bump.height = q_item.peak_height;
		wr_bump.skew = {q_item.skew_x[15], q_item.skew_x};
		wr_bump.shape = q_item.shape_y;
		q_pop = (state_q == S_IDLE) && q_valid;
		ram_we = q_pop && (q_item.kind == ITEM_WRITE);
	end

	always_comb begin
		n_eff = (sample_count < 13'd2) ? 13'd2 : sample_count;
		nm1 = n_eff - 13'd1;
		i_eff = ({1'b0, q_item.sample_index} > nm1) ? nm1[11:0] : q_item.sample_index;
		if (int'(active_count) > MAX_GAUSSIANS) begin
			cnt_eff = CNTW'(MAX_GAUSSIANS);
		end else begin
			cnt_eff = CNTW'(active_count);
		end
		last = (e_q + CNTW'(1)) == cnt_q;
	end

	always_comb begin
		xs = signed'({4'b0, x_q});
		ps = signed'({4'b0, bump.center});
		ws = signed'({4'b0, bump.width});
		w1s = (bump.width == 16'd0) ? 20'sd1 : ws;
		bxs = signed'({{3{bump.skew[16]}}, bump.skew});
		outside = (xs > ps + ws) || (xs < ps - ws);
		ds = xs - ps - bxs;
		dens = (ds > 0) ? w1s - bxs : w1s + bxs;
		mag = (ds < 0) ? 18'(-ds) : 18'(ds);
		den_u = dens[17:0];
		skip_div = (ds == 0) || (dens <= 0);
	end

	always_comb begin
		div_req.start = 1'b0;
		div_req.num = '0;
		div_req.den = '0;
		if (state_q == S_IDLE || state_q == S_POS) begin
			div_req.start = q_pop && (q_item.kind == ITEM_EVAL);
			div_req.num = DIV_NW'({i_eff, 15'd0}) + DIV_NW'(nm1 >> 1);
			div_req.den = DIV_DW'(nm1);
		end else begin
			div_req.start = (state_q == S_CHK) && !outside && !skip_div;
			div_req.num = DIV_NW'({mag, 15'd0}) + DIV_NW'(den_u >> 1);
			div_req.den = den_u;
		end
	end

	always_comb begin
		sq = 34'(x1_q) * 34'(x1_q) + 34'(HALF_Q);

		gpos = {s_q, EXP_AW'(0)} - PW'(s_q);
		gk = gpos[PW-1:FRAC_BITS];
		gfr = gpos[FRAC_BITS-1:0];
		ta = EXP_TAB[gk[EXP_AW-1:0]];
		tb = EXP_TAB[EXP_AW'(gk[EXP_AW-1:0] + EXP_AW'(1))];
		tdiff = (ta >= tb) ? ta - tb : tb - ta;
		gprod = 32'(tdiff) * 32'(gfr) + 32'(HALF_Q);
		gstep = gprod[31:15];
		if (gk >= (EXP_AW + 1)'(EXP_DEPTH - 1)) begin
			g_next = EXP_TAB[EXP_DEPTH-1];
		end else if (ta >= tb) begin
			g_next = 16'(17'(ta) - gstep);
		end else begin
			g_next = 16'(17'(ta) + gstep);
		end

		by = ({bump.shape, 1'b0} > TWO17) ? TWO17 : {bump.shape, 1'b0};
		pb = ONE17 - {1'b0, s_q};
		if (by < ONE17) begin
			m1 = 34'(by) * 34'(pb);
			m2 = 34'(ONE17 - by) * 34'(g_q);
		end else begin
			m1 = 34'(TWO17 - by) * 34'(pb);
			m2 = 34'(by - ONE17) << FRAC_BITS;
		end
		bsum = m1 + m2 + 34'(HALF_Q);

		hprod = 34'(bump.height) * 34'(h1_q) + 34'(HALF_Q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_pop && q_item.kind == ITEM_EVAL) begin
						state_q <= S_POS;
					end
				end
				S_POS: begin
					if (div_done) begin
						state_q <= (cnt_eff == '0) ? S_OUT : S_RD;
					end
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					if (outside) begin
						state_q <= last ? S_OUT : S_RD;
					end else begin
						state_q <= skip_div ? S_SQ : S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_SQ;
					end
				end
				S_SQ: state_q <= S_GL;
				S_GL: state_q <= S_BL;
				S_BL: state_q <= S_HV;
				S_HV: state_q <= last ? S_OUT : S_RD;
				S_OUT: begin
					state_q <= S_IDLE;
					done_q <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_POS: begin
				x_q <= div_quo[15:0];
				cnt_q <= cnt_eff;
				e_q <= '0;
				best_q <= '0;
			end
			S_CHK: begin
				x1_q <= '0;
				if (outside && !last) begin
					e_q <= e_q + CNTW'(1);
				end
			end
			S_DIV: begin
				x1_q <= (div_quo > DIV_NW'(ONE_Q)) ? ONE17 : div_quo[16:0];
			end
			S_SQ: s_q <= sq[30:15];
			S_GL: g_q <= g_next;
			S_BL: h1_q <= bsum[31:15];
			S_HV: begin
				if (hprod[33:15] > best_q) begin
					best_q <= hprod[33:15];
				end
				if (!last) begin
					e_q <= e_q + CNTW'(1);
				end
			end
			S_OUT: opacity_q <= (best_q > 19'h0FFFF) ? 16'hFFFF : best_q[15:0];
			default: ;
		endcase
	end

	goce_ram #(
		.WIDTH(BW),
		.DEPTH(MAX_GAUSSIANS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(IW'(q_item.entry_index)),
		.wdata(wr_bump),
		.raddr(e_q[IW-1:0]),
		.rdata(ram_rdata)
	);

	goce_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.done  (div_done),
		.quo   (div_quo)
	);

	assign done = done_q;
	assign opacity = opacity_q;

endmodule

### rtl/gaussian_opacity_curve_eval.sv
// A transaction is taken on start while busy is low; busy rises only when the two-entry
// queue in front of the evaluator is full. A table write leaves the queue once the
// evaluator is idle and produces no result. An evaluation places the sample, then
// remaps and shapes each active entry that covers it; the shared 34-step divider
// that computes the sample position and each entry's remapped offset sets most of
// its time. The result appears on opacity with done high for exactly one cycle and
// must be taken then, since the receiver cannot stall. The user must write configuration
// registers only while no transaction is outstanding; the block does not check this.
module gaussian_opacity_curve_eval #(
	parameter int MAX_GAUSSIANS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               mode,
	input  logic [3:0]         entry_index,
	input  logic [15:0]        center,
	input  logic [15:0]        half_width,
	input  logic [15:0]        peak_height,
	input  logic signed [15:0] skew_x,
	input  logic [15:0]        shape_y,
	input  logic [11:0]        sample_index,
	output logic               done,
	output logic [15:0]        opacity,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [12:0]        cfg_data
);

	import goce_pkg::*;

	logic        q_valid;
	item_t       q_item;
	logic        q_pop;
	logic [4:0]  active_count_q;
	logic [12:0] sample_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_count_q <= 5'd0;
			sample_count_q <= 13'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ACTIVE_COUNT: active_count_q <= cfg_data[4:0];
				CFG_SAMPLE_COUNT: sample_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	goce_front #(
		.MAX_GAUSSIANS(MAX_GAUSSIANS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.mode        (mode),
		.entry_index (entry_index),
		.center      (center),
		.half_width  (half_width),
		.peak_height (peak_height),
		.skew_x      (skew_x),
		.shape_y     (shape_y),
		.sample_index(sample_index),
		.busy        (busy),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop)
	);

	goce_back #(
		.MAX_GAUSSIANS(MAX_GAUSSIANS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.active_count(active_count_q),
		.sample_count(sample_count_q),
		.done        (done),
		.opacity     (opacity)
	);

endmodule

### rtl/goce_checker.sv
module goce_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// Every evaluation runs through the divider, so results are far apart.
	a_done_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done ##1 !done)
		else $error("results closer than three cycles");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a transaction");

	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !done && !busy)
		else $error("outputs active after reset");

endmodule

bind gaussian_opacity_curve_eval goce_checker u_goce_checker (.*);

### tb/tb.sv
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import goce_pkg::*;

	localparam int  SLOTS       = 16;
	localparam longint UNIT     = 64'd1 << 15;
	localparam longint HALF     = 64'd1 << 14;
	localparam int  LUT_DEPTH   = 256;
	localparam longint CYCLE_LIMIT = 4000000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               mode = 1'b0;
	logic [3:0]         entry_index = '0;
	logic [15:0]        center = '0;
	logic [15:0]        half_width = '0;
	logic [15:0]        peak_height = '0;
	logic signed [15:0] skew_x = '0;
	logic [15:0]        shape_y = '0;
	logic [11:0]        sample_index = '0;
	logic               done;
	logic [15:0]        opacity;
	logic               cfg_we = 1'b0;
	logic               cfg_index = CFG_ACTIVE_COUNT;
	logic [12:0]        cfg_data = '0;

	gaussian_opacity_curve_eval uut (.*);

	always #1 clk = ~clk;

	longint      decay_lut [LUT_DEPTH];
	logic [15:0] tab_center [SLOTS];
	logic [15:0] tab_width [SLOTS];
	logic [15:0] tab_height [SLOTS];
	longint      tab_skew [SLOTS];
	logic [15:0] tab_shape [SLOTS];
	logic [4:0]  bumps_in_use;
	logic [12:0] sample_span;

	logic [15:0] pending_opacity [$];
	int          errors = 0;
	int          results_seen = 0;
	int          writes_sent = 0;
	int          evals_sent = 0;
	int          sender_idle_pct = 0;
	longint      cycles = 0;

	function automatic void build_decay_lut();
		longint unsigned last;
		longint unsigned r;
		longint unsigned acc;
		longint unsigned term;
		longint unsigned q31;
		q31 = 64'h8000_0000;
		last = LUT_DEPTH - 1;
		for (int k = 0; k < LUT_DEPTH; k++) begin
			r = ((longint'(k) << 31) + 2 * last) / (4 * last);
			acc = q31;
			term = q31;
			for (int n = 1; n <= 12; n++) begin
				term = ((term * r) >> 31) / longint'(n);
				if (n % 2 == 1) begin
					acc = acc - term;
				end else begin
					acc = acc + term;
				end
			end
			for (int i = 0; i < 4; i++) begin
				acc = (acc * acc + (q31 >> 1)) >> 31;
			end
			decay_lut[k] = longint'((acc + (64'd1 << 15)) >> 16);
		end
	endfunction

	function automatic longint gaussian_of(longint s);
		longint p;
		longint k;
		longint fr;
		longint a;
		longint b;
		p = s * (LUT_DEPTH - 1);
		k = p >>> 15;
		fr = p & (UNIT - 1);
		if (k >= LUT_DEPTH - 1) begin
			return decay_lut[LUT_DEPTH - 1];
		end
		a = decay_lut[k];
		b = decay_lut[k + 1];
		if (a >= b) begin
			return a - (((a - b) * fr + HALF) >>> 15);
		end
		return a + (((b - a) * fr + HALF) >>> 15);
	endfunction

	function automatic longint bump_height_at(longint x, int e);
		longint c;
		longint w;
		longint bx;
		longint by;
		longint d;
		longint x1;
		longint den;
		longint mag;
		longint s;
		longint g;
		longint pb;
		longint h1;
		c = tab_center[e];
		w = tab_width[e];
		bx = tab_skew[e];
		by = longint'(tab_shape[e]) * 2;
		if (x > c + w || x < c - w) begin
			return 0;
		end
		if (w == 0) begin
			w = 1;
		end
		d = x - c - bx;
		x1 = 0;
		if (d != 0) begin
			den = (d > 0) ? (w - bx) : (w + bx);
			mag = (d > 0) ? d : -d;
			if (den > 0) begin
				x1 = ((mag << 15) + den / 2) / den;
				if (x1 > UNIT) begin
					x1 = UNIT;
				end
			end
		end
		s = (x1 * x1 + HALF) >>> 15;
		g = gaussian_of(s);
		pb = UNIT - s;
		if (by > 2 * UNIT) begin
			by = 2 * UNIT;
		end
		if (by < UNIT) begin
			h1 = (by * pb + (UNIT - by) * g + HALF) >>> 15;
		end else begin
			h1 = ((2 * UNIT - by) * pb + (by - UNIT) * UNIT + HALF) >>> 15;
		end
		return (longint'(tab_height[e]) * h1 + HALF) >>> 15;
	endfunction

	function automatic logic [15:0] opacity_at(logic [11:0] idx);
		longint n;
		longint i;
		longint x;
		longint best;
		longint v;
		int     live;
		n = (sample_span < 2) ? 2 : sample_span;
		i = (idx > n - 1) ? n - 1 : idx;
		x = (i * UNIT + (n - 1) / 2) / (n - 1);
		live = (bumps_in_use > SLOTS) ? SLOTS : bumps_in_use;
		best = 0;
		for (int e = 0; e < live; e++) begin
			v = bump_height_at(x, e);
			if (v > best) begin
				best = v;
			end
		end
		if (best > 16'hFFFF) begin
			best = 16'hFFFF;
		end
		return best[15:0];
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
		if (arst_n && done) begin
			results_seen <= results_seen + 1;
			if (pending_opacity.size() == 0) begin
				$error("opacity: unexpected result %0d", opacity);
				errors <= errors + 1;
			end else begin
				if (opacity !== pending_opacity[0]) begin
					$error("opacity expected %0d actual %0d", pending_opacity[0], opacity);
					errors <= errors + 1;
				end
				void'(pending_opacity.pop_front());
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_item(item_kind_t kind, logic [3:0] ei, logic [15:0] c,
			logic [15:0] w, logic [15:0] h, logic [15:0] sk, logic [15:0] sh,
			logic [11:0] si);
		if ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		mode <= (kind == ITEM_EVAL);
		entry_index <= ei;
		center <= c;
		half_width <= w;
		peak_height <= h;
		skew_x <= sk;
		shape_y <= sh;
		sample_index <= si;
		start <= 1'b1;
		while (busy) @(negedge clk);
		@(posedge clk);
		if (kind == ITEM_WRITE) begin
			tab_center[ei] = c;
			tab_width[ei] = w;
			tab_height[ei] = h;
			tab_skew[ei] = longint'(signed'(sk));
			tab_shape[ei] = sh;
			writes_sent++;
		end else begin
			pending_opacity = {pending_opacity, opacity_at(si)};
			evals_sent++;
		end
		@(negedge clk);
	endtask

	task automatic write_bump(int ei, int c, int w, int h, int sk, int sh);
		send_item(ITEM_WRITE, ei[3:0], c[15:0], w[15:0], h[15:0], sk[15:0], sh[15:0],
			12'($urandom));
	endtask

	task automatic eval_sample(int si);
		send_item(ITEM_EVAL, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom), si[11:0]);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_opacity.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic set_register(logic idx, int value);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[12:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_ACTIVE_COUNT) begin
			bumps_in_use = value[4:0];
		end else begin
			sample_span = value[12:0];
		end
	endtask

	task automatic test_empty_table();
		set_register(CFG_ACTIVE_COUNT, 0);
		eval_sample(0);
		eval_sample(4095);
	endtask

	task automatic test_table_extremes();
		write_bump(0, 0, 0, 32768, 0, 0);
		write_bump(1, 32768, 32768, 32768, 0, 32768);
		write_bump(2, 16384, 4096, 32768, 4096, 16384);
		write_bump(3, 16384, 4096, 20000, -4096, 65535);
		write_bump(4, 65535, 65535, 65535, -32768, 24000);
		write_bump(5, 8000, 2000, 30000, 32767, 8000);
		for (int e = 6; e < SLOTS; e++) begin
			write_bump(e, $urandom_range(32768), $urandom_range(8000),
				$urandom_range(32768), $urandom_range(65535), $urandom_range(32768));
		end
		set_register(CFG_ACTIVE_COUNT, 16);
	endtask

	task automatic test_sample_position();
		set_register(CFG_SAMPLE_COUNT, 0);
		eval_sample(0);
		eval_sample(1);
		eval_sample(4095);
		set_register(CFG_SAMPLE_COUNT, 8191);
		eval_sample(2048);
		eval_sample(4095);
		set_register(CFG_ACTIVE_COUNT, 31);
		eval_sample(0);
	endtask

	task automatic test_random_traffic(int idle_pct);
		int counts[7] = '{0, 1, 2, 5, 16, 31, 0};
		int spans[8]  = '{2, 3, 17, 256, 4096, 8191, 1, 0};
		int w;
		int n;
		sender_idle_pct = idle_pct;
		for (int round = 0; round < 4; round++) begin
			counts[6] = $urandom_range(31);
			set_register(CFG_ACTIVE_COUNT, counts[$urandom_range(6)]);
			set_register(CFG_SAMPLE_COUNT,
				($urandom_range(3) == 0) ? $urandom_range(8191) : spans[$urandom_range(7)]);
			n = (sample_span < 2) ? 2 : sample_span;
			for (int k = 0; k < 90; k++) begin
				if ($urandom_range(9) < 4) begin
					if ($urandom_range(9) == 0) begin
						write_bump($urandom_range(15), $urandom_range(65535),
							$urandom_range(65535), $urandom_range(65535),
							$urandom_range(65535), $urandom_range(65535));
					end else begin
						w = $urandom_range(12000);
						write_bump($urandom_range(15), $urandom_range(32768), w,
							$urandom_range(32768), $urandom_range(2 * w) - w,
							$urandom_range(32768));
					end
				end else begin
					eval_sample(($urandom_range(7) == 0) ? $urandom_range(4095)
						: $urandom_range(n > 4096 ? 4095 : n - 1));
				end
			end
		end
	endtask

	initial begin
		build_decay_lut();
		bumps_in_use = 0;
		sample_span = 256;
		for (int e = 0; e < SLOTS; e++) begin
			tab_center[e] = 0;
			tab_width[e] = 0;
			tab_height[e] = 0;
			tab_skew[e] = 0;
			tab_shape[e] = 0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_empty_table();
		test_table_extremes();
		test_sample_position();
		test_random_traffic(8);
		test_random_traffic(45);
		test_random_traffic(0);
		drain();
		if (pending_opacity.size() != 0) begin
			$error("opacity: %0d results never arrived", pending_opacity.size());
			errors++;
		end
		$display("tb: %0d table writes and %0d evaluations sent, %0d results checked",
			writes_sent, evals_sent, results_seen);
		$display("tb: covered extreme counts, sample spans and sender idling levels");
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule

`default_nettype wire
